// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH   = 1024;
  localparam int WORD_W  = 32;
  localparam int FUNC_W  = 3;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [COUNT_W-1:0]       count_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_QUERY      = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    SH_HOLD  = 2'd0,
    SH_RIGHT = 2'd1,
    SH_LEFT  = 2'd2
  } shift_e;

  typedef struct packed {
    shift_e a_shift;
    shift_e b_shift;
    shift_e m_shift;
    logic   a_tail_wr;
    logic   b_tail_wr;
  } cell_ctrl_t;

endpackage

// ===== rtl/double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded deque of signed words built from a row of shifting cells.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle while the input is not stalled and
// shows its result in the cycle after acceptance; the cell row shifts or writes
// all of its slots together. Each slot keeps the queue in front order and
// in back order plus a tail marker, so the front and back words and the
// popped word are always read at the first cell. Input is stalled only while
// a result waits on a stalled output. A push to a full queue and a pop from an
// empty queue leave the queue unchanged and raise their flags.
module double_ended_queue_unit
  import deq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [FUNC_W-1:0]  func_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] popped_value_o,
  output logic               pop_failed_o,
  output logic               push_rejected_o,
  output logic [COUNT_W-1:0] entry_count_o,
  output logic               is_empty_o,
  output logic signed [31:0] front_value_o,
  output logic signed [31:0] back_value_o
);

  cell_ctrl_t ctrl;
  logic       full;
  word_t      a_head, b_head;
  count_t     count;

  deq_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .a_head_i        (a_head),
    .b_head_i        (b_head),
    .ctrl_o          (ctrl),
    .full_o          (full),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .popped_o        (popped_value_o),
    .pop_failed_o    (pop_failed_o),
    .push_rejected_o (push_rejected_o),
    .count_o         (count)
  );

  deq_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .data_i   (push_value_i),
    .full_i   (full),
    .a_head_o (a_head),
    .b_head_o (b_head)
  );

  assign entry_count_o = count;
  assign is_empty_o    = (count == '0);
  assign front_value_o = is_empty_o ? '0 : a_head;
  assign back_value_o  = is_empty_o ? '0 : b_head;

endmodule

// ===== rtl/deq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_cell
// One slot of the queue: front-ordered word, back-ordered word, tail marker.
// ----------------------------------------------------------------------------
module deq_cell
  import deq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  word_t      data_i,
  input  logic       mark_init_i,
  input  word_t      a_left_i,
  input  word_t      a_right_i,
  input  word_t      b_left_i,
  input  word_t      b_right_i,
  input  logic       m_left_i,
  input  logic       m_right_i,
  output word_t      a_o,
  output word_t      b_o,
  output logic       m_o
);

  word_t a_q, a_d;
  word_t b_q, b_d;
  logic  m_q, m_d;

  always_comb begin
    case (ctrl_i.a_shift)
      SH_RIGHT: a_d = a_left_i;
      SH_LEFT:  a_d = a_right_i;
      default:  a_d = (ctrl_i.a_tail_wr && m_q) ? data_i : a_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.b_shift)
      SH_RIGHT: b_d = b_left_i;
      SH_LEFT:  b_d = b_right_i;
      default:  b_d = (ctrl_i.b_tail_wr && m_q) ? data_i : b_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.m_shift)
      SH_RIGHT: m_d = m_left_i;
      SH_LEFT:  m_d = m_right_i;
      default:  m_d = m_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= mark_init_i;
    end else begin
      m_q <= m_d;
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;
  assign m_o = m_q;

endmodule

// ===== rtl/deq_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_chain
// Row of queue cells; exposes the front and back words at cell zero.
// ----------------------------------------------------------------------------
module deq_chain
  import deq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  word_t      data_i,
  input  logic       full_i,
  output word_t      a_head_o,
  output word_t      b_head_o
);

  word_t a_w [DEPTH];
  word_t b_w [DEPTH];
  logic  m_w [DEPTH];
  word_t a_l [DEPTH];
  word_t a_r [DEPTH];
  word_t b_l [DEPTH];
  word_t b_r [DEPTH];
  logic  m_l [DEPTH];
  logic  m_r [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign a_l[i] = data_i;
      assign b_l[i] = data_i;
      assign m_l[i] = 1'b0;
    end else begin : g_inner_l
      assign a_l[i] = a_w[i-1];
      assign b_l[i] = b_w[i-1];
      assign m_l[i] = m_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign a_r[i] = a_w[i];
      assign b_r[i] = b_w[i];
      assign m_r[i] = full_i;
    end else begin : g_inner_r
      assign a_r[i] = a_w[i+1];
      assign b_r[i] = b_w[i+1];
      assign m_r[i] = m_w[i+1];
    end

    deq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_i),
      .data_i      (data_i),
      .mark_init_i ((i == 0) ? 1'b1 : 1'b0),
      .a_left_i    (a_l[i]),
      .a_right_i   (a_r[i]),
      .b_left_i    (b_l[i]),
      .b_right_i   (b_r[i]),
      .m_left_i    (m_l[i]),
      .m_right_i   (m_r[i]),
      .a_o         (a_w[i]),
      .b_o         (b_w[i]),
      .m_o         (m_w[i])
    );
  end

  assign a_head_o = a_w[0];
  assign b_head_o = b_w[0];

endmodule

// ===== rtl/deq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Operation decode, entry count and result register of the queue.
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FUNC_W-1:0] func_i,
  input  word_t             a_head_i,
  input  word_t             b_head_i,
  output cell_ctrl_t        ctrl_o,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output word_t             popped_o,
  output logic              pop_failed_o,
  output logic              push_rejected_o,
  output count_t            count_o
);

  logic   accept;
  logic   full, empty;
  func_e  func;
  logic   out_valid_q, out_valid_d;
  count_t count_q, count_d;
  word_t  popped_d, popped_q;
  logic   pop_failed_d, pop_failed_q;
  logic   rejected_d, rejected_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == COUNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign func       = func_e'(func_i);

  always_comb begin
    ctrl_o       = '{a_shift: SH_HOLD, b_shift: SH_HOLD, m_shift: SH_HOLD,
                     a_tail_wr: 1'b0, b_tail_wr: 1'b0};
    count_d      = count_q;
    popped_d     = '0;
    pop_failed_d = 1'b0;
    rejected_d   = 1'b0;
    if (accept) begin
      case (func)
        FUNC_PUSH_FRONT: begin
          if (full) begin
            rejected_d = 1'b1;
          end else begin
            ctrl_o.a_shift   = SH_RIGHT;
            ctrl_o.b_tail_wr = 1'b1;
            ctrl_o.m_shift   = SH_RIGHT;
            count_d          = count_q + 1'b1;
          end
        end
        FUNC_PUSH_BACK: begin
          if (full) begin
            rejected_d = 1'b1;
          end else begin
            ctrl_o.b_shift   = SH_RIGHT;
            ctrl_o.a_tail_wr = 1'b1;
            ctrl_o.m_shift   = SH_RIGHT;
            count_d          = count_q + 1'b1;
          end
        end
        FUNC_POP_FRONT: begin
          if (empty) begin
            pop_failed_d = 1'b1;
          end else begin
            popped_d       = a_head_i;
            ctrl_o.a_shift = SH_LEFT;
            ctrl_o.m_shift = SH_LEFT;
            count_d        = count_q - 1'b1;
          end
        end
        FUNC_POP_BACK: begin
          if (empty) begin
            pop_failed_d = 1'b1;
          end else begin
            popped_d       = b_head_i;
            ctrl_o.b_shift = SH_LEFT;
            ctrl_o.m_shift = SH_LEFT;
            count_d        = count_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q     <= popped_d;
      pop_failed_q <= pop_failed_d;
      rejected_q   <= rejected_d;
    end
  end

  assign full_o          = full;
  assign out_valid_o     = out_valid_q;
  assign popped_o        = popped_q;
  assign pop_failed_o    = pop_failed_q;
  assign push_rejected_o = rejected_q;
  assign count_o         = count_q;

endmodule

// ===== rtl/deq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks of the double-ended queue unit, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker
  import deq_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [FUNC_W-1:0]  func_i,
  input logic signed [31:0] push_value_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] popped_value_o,
  input logic               pop_failed_o,
  input logic               push_rejected_o,
  input logic [COUNT_W-1:0] entry_count_o,
  input logic               is_empty_o,
  input logic signed [31:0] front_value_o,
  input logic signed [31:0] back_value_o
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(entry_count_o)
      && $stable(popped_value_o))
    else $error("stalled result changed");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(pop_failed_o && push_rejected_o))
    else $error("pop and push flags both set");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= COUNT_W'(DEPTH))
    else $error("entry count above depth");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> front_value_o == 0 && back_value_o == 0
      && entry_count_o == 0)
    else $error("empty queue shows data");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pop_failed_o |-> popped_value_o == 0 && is_empty_o)
    else $error("failed pop shows data");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (.*);

// ===== test/tb_double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_unit
// Self-checking bench for the double-ended queue unit.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own deque of words and predicts, for every accepted
// item, the popped word, the empty-pop and full-push flags, the entry count and
// the front and back words. A short directed run hits empty pops, word extremes
// and the unused function codes. Random traffic follows in three phases. The
// first is balanced around an empty queue. The second is push-heavy and fills
// the queue until pushes are rejected. The third stays near full while the
// receiver holds off for a long stretch. Both handshakes idle at random, with
// the sender and receiver rates swapped between phases and dropped in the last.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_unit;
  import deq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    word_t  popped;
    logic   pop_failed;
    logic   push_rejected;
    count_t count;
    logic   empty;
    word_t  front;
    word_t  back;
  } deq_result_t;

  class deque_scoreboard;
    word_t       words[$];
    deq_result_t awaited[$];
    int          errors;
    int          rejects;

    function void note_item(logic [FUNC_W-1:0] func, word_t value);
      deq_result_t r;
      r = '{default: '0};
      if (func == FUNC_PUSH_FRONT || func == FUNC_PUSH_BACK) begin
        if (words.size() >= DEPTH) begin
          r.push_rejected = 1'b1;
          rejects++;
        end else if (func == FUNC_PUSH_FRONT) begin
          words.insert(0, value);
        end else begin
          words.insert(words.size(), value);
        end
      end else if (func == FUNC_POP_FRONT || func == FUNC_POP_BACK) begin
        if (words.size() == 0) begin
          r.pop_failed = 1'b1;
        end else if (func == FUNC_POP_FRONT) begin
          r.popped = words[0];
          words.delete(0);
        end else begin
          r.popped = words[words.size()-1];
          words.delete(words.size()-1);
        end
      end
      r.count = count_t'(words.size());
      r.empty = (words.size() == 0);
      if (words.size() != 0) begin
        r.front = words[0];
        r.back  = words[words.size()-1];
      end
      awaited.insert(awaited.size(), r);
    endfunction

    function void compare(string name, logic signed [31:0] exp, logic signed [31:0] act);
      if (exp !== act) begin
        if (errors < MAX_REPORTS)
          $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(deq_result_t got);
      deq_result_t exp;
      if (awaited.size() == 0) begin
        if (errors < MAX_REPORTS) $display("%0t result with no item pending", $time);
        errors++;
        return;
      end
      exp = awaited[0];
      awaited.delete(0);
      compare("popped_value", exp.popped, got.popped);
      compare("pop_failed", 32'(exp.pop_failed), 32'(got.pop_failed));
      compare("push_rejected", 32'(exp.push_rejected), 32'(got.push_rejected));
      compare("entry_count", 32'(exp.count), 32'(got.count));
      compare("is_empty", 32'(exp.empty), 32'(got.empty));
      compare("front_value", exp.front, got.front);
      compare("back_value", exp.back, got.back);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [FUNC_W-1:0]  func_i = FUNC_QUERY;
  logic signed [31:0] push_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] popped_value_o;
  logic               pop_failed_o;
  logic               push_rejected_o;
  logic [COUNT_W-1:0] entry_count_o;
  logic               is_empty_o;
  logic signed [31:0] front_value_o;
  logic signed [31:0] back_value_o;

  deque_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit pressure_on = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;

  double_ended_queue_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .push_value_i    (push_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .popped_value_o  (popped_value_o),
    .pop_failed_o    (pop_failed_o),
    .push_rejected_o (push_rejected_o),
    .entry_count_o   (entry_count_o),
    .is_empty_o      (is_empty_o),
    .front_value_o   (front_value_o),
    .back_value_o    (back_value_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    deq_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.popped        = popped_value_o;
      got.pop_failed    = pop_failed_o;
      got.push_rejected = push_rejected_o;
      got.count         = entry_count_o;
      got.empty         = is_empty_o;
      got.front         = front_value_o;
      got.back          = back_value_o;
      sb.check_result(got);
    end
    if (pressure_on && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_item(input logic [FUNC_W-1:0] func, input word_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= func;
    push_value_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(func, value);
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(input int push_pct, input int pop_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_pct)
      return $urandom_range(1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
    if (roll < push_pct + pop_pct)
      return $urandom_range(1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
    if (roll < 97)
      return FUNC_QUERY;
    return FUNC_W'($urandom_range(7, FUNC_QUERY + 1));
  endfunction

  initial begin
    int guard;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 16;
    recv_idle_pct = 61;
    send_item(FUNC_POP_FRONT, 32'sh1234_5678);
    send_item(FUNC_POP_BACK, -32'sd1);
    send_item(FUNC_QUERY, 32'sh7FFF_FFFF);
    send_item(FUNC_W'(FUNC_QUERY + 1), -32'sd1);
    send_item(FUNC_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_item(FUNC_PUSH_BACK, 32'sh8000_0000);
    send_item(FUNC_QUERY, '0);
    send_item(FUNC_PUSH_FRONT, -32'sd1);
    send_item(FUNC_PUSH_BACK, '0);
    send_item(FUNC_W'(FUNC_QUERY + 2), 32'sh5555_5555);
    send_item(FUNC_W'(FUNC_QUERY + 3), 32'shAAAA_AAAA);
    send_item(FUNC_POP_FRONT, '0);
    send_item(FUNC_POP_BACK, '0);
    send_item(FUNC_POP_FRONT, '0);
    send_item(FUNC_POP_BACK, '0);
    send_item(FUNC_POP_BACK, '0);
    send_item(FUNC_PUSH_BACK, 32'sh5555_5555);
    send_item(FUNC_PUSH_FRONT, 32'shAAAA_AAAA);
    send_item(FUNC_POP_FRONT, '0);
    send_item(FUNC_POP_FRONT, '0);
    send_item(FUNC_PUSH_FRONT, 32'sd1);
    send_item(FUNC_POP_BACK, '0);
    send_item(FUNC_POP_FRONT, '0);
    send_item(FUNC_PUSH_BACK, 32'sh8000_0000);

    repeat (40) send_item(pick_func(45, 45), pick_word());

    send_idle_pct = 61;
    recv_idle_pct = 16;
    guard = 0;
    while (sb.rejects < 10 && guard < 1400) begin
      send_item(pick_func(98, 1), pick_word());
      guard++;
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    pressure_on   = 1'b1;
    repeat (40) send_item(pick_func(50, 45), pick_word());

    in_valid_i <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
